/* src/skt_pkg.sv */
// ---------------------------------------------------------------------------
// skt_pkg
// Shared constants, status codes and control bundles for the string keyed
// hash table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int CHAR_W     = 8;
  localparam int AGE_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 7;

  localparam int DEF_TABLE_ENTRIES = 100;
  localparam int DEF_NAME_BYTES    = 50;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd2;

  typedef struct packed {
    logic             start;
    logic             is_find;
    logic [AGE_W-1:0] age;
  } tbl_req_t;

  typedef struct packed {
    logic                ready;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [AGE_W-1:0]    found_age;
  } tbl_resp_t;

endpackage

`default_nettype wire

/* src/skt_hash.sv */
// ---------------------------------------------------------------------------
// skt_hash
// Three stage hash step: h' = ((h + c) * c) mod TABLE_ENTRIES, with the
// modulo done as a reciprocal multiply and a constant multiply-subtract.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_hash #(
  parameter int TABLE_ENTRIES = skt_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0]   h_in,
  input  wire logic [skt_pkg::CHAR_W-1:0]         char_in,
  output logic                                    done,
  output logic [$clog2(TABLE_ENTRIES)-1:0]        h_out
);
  import skt_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int SUM_W  = ((SLOT_W > CHAR_W) ? SLOT_W : CHAR_W) + 1;
  localparam int P_W    = SUM_W + CHAR_W;
  localparam int K      = P_W + SLOT_W;
  localparam int M_W    = P_W + 2;
  localparam int PR_W   = P_W + M_W;
  localparam int QT_W   = P_W + SLOT_W + 1;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << K) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [M_W-1:0] RECIP = M_W'(RECIP_WIDE);

  logic              v1_r, v2_r, v3_r;
  logic [P_W-1:0]    p1_r, p2_r, q2_r;
  logic [SLOT_W-1:0] h3_r;

  logic [SUM_W-1:0]  sum;
  logic [P_W-1:0]    p1_nxt, q2_nxt;
  logic [PR_W-1:0]   recip_prod;
  logic [QT_W-1:0]   qt, r_full;
  logic [SLOT_W:0]   r_low;
  logic [SLOT_W-1:0] h3_nxt;

  always_comb begin
    sum        = SUM_W'(h_in) + SUM_W'(char_in);
    p1_nxt     = P_W'(sum) * P_W'(char_in);
    recip_prod = PR_W'(p1_r) * PR_W'(RECIP);
    q2_nxt     = P_W'(recip_prod >> K);
    qt         = QT_W'(q2_r) * QT_W'(TABLE_ENTRIES);
    r_full     = QT_W'(p2_r) - qt;
    r_low      = r_full[SLOT_W:0];
    if (r_low >= (SLOT_W+1)'(TABLE_ENTRIES)) begin
      h3_nxt = SLOT_W'(r_low - (SLOT_W+1)'(TABLE_ENTRIES));
    end else begin
      h3_nxt = SLOT_W'(r_low);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p1_r;
    q2_r <= q2_nxt;
    h3_r <= h3_nxt;
  end

  assign done  = v3_r;
  assign h_out = h3_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 done)
    else $error("hash step did not finish in three cycles");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (32'(h_out) < TABLE_ENTRIES))
    else $error("hash result out of table range");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!v1_r && !v2_r))
    else $error("hash step started while another is in flight");

endmodule

`default_nettype wire

/* src/skt_table.sv */
// ---------------------------------------------------------------------------
// skt_table
// Table storage (valid, age, name bytes) plus the key buffer, with a
// sequencer for the reset clear pass, insert copy and find compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_table #(
  parameter int TABLE_ENTRIES = skt_pkg::DEF_TABLE_ENTRIES,
  parameter int NAME_BYTES    = skt_pkg::DEF_NAME_BYTES
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          kwr_en,
  input  wire logic [((NAME_BYTES > 2) ? $clog2(NAME_BYTES-1) : 1)-1:0] kwr_addr,
  input  wire logic [skt_pkg::CHAR_W-1:0]                    kwr_data,
  input  wire skt_pkg::tbl_req_t                             req,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0]              req_slot,
  input  wire logic [$clog2(NAME_BYTES)-1:0]                 req_len,
  input  wire logic                                          resp_ack,
  output skt_pkg::tbl_resp_t                                 resp
);
  import skt_pkg::*;

  localparam int KEY_MAX    = NAME_BYTES - 1;
  localparam int SLOT_W     = $clog2(TABLE_ENTRIES);
  localparam int LEN_W      = $clog2(NAME_BYTES);
  localparam int KIDX_W     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int NAME_DEPTH = TABLE_ENTRIES * KEY_MAX;
  localparam int NADDR_W    = $clog2(NAME_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [KIDX_W-1:0] KEY_LAST  = KIDX_W'(KEY_MAX - 1);

  localparam logic [2:0] TS_CLEAR = 3'd0;
  localparam logic [2:0] TS_IDLE  = 3'd1;
  localparam logic [2:0] TS_CHECK = 3'd2;
  localparam logic [2:0] TS_RUN   = 3'd3;
  localparam logic [2:0] TS_DONE  = 3'd4;

  logic                valid_mem [TABLE_ENTRIES];
  logic [AGE_W-1:0]    age_mem   [TABLE_ENTRIES];
  logic [CHAR_W-1:0]   name_mem  [NAME_DEPTH];
  logic [CHAR_W-1:0]   key_mem   [KEY_MAX];

  logic [2:0]          st_r, st_nxt;
  logic [SLOT_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic                issuing_r, issuing_nxt;
  logic                pv_r, pv_nxt;
  logic [KIDX_W-1:0]   idx_r, idx_nxt;
  logic [KIDX_W-1:0]   pidx_r, pidx_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                find_r, find_nxt;
  logic [AGE_W-1:0]    age_in_r, age_in_nxt;
  logic [NADDR_W-1:0]  base_r, base_nxt;
  logic                mism_r, mism_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [AGE_W-1:0]    fage_r, fage_nxt;

  logic                valid_q_r;
  logic [AGE_W-1:0]    age_q_r;
  logic [CHAR_W-1:0]   name_q_r, key_q_r;

  logic                v_we, v_wd, a_we, n_we, n_re;
  logic [SLOT_W-1:0]   v_wa;
  logic [NADDR_W-1:0]  n_wa, n_ra;
  logic [CHAR_W-1:0]   key_byte;
  logic                byte_diff;

  always_comb begin
    st_nxt      = st_r;
    clr_idx_nxt = clr_idx_r;
    issuing_nxt = issuing_r;
    pv_nxt      = 1'b0;
    idx_nxt     = idx_r;
    pidx_nxt    = pidx_r;
    slot_nxt    = slot_r;
    len_nxt     = len_r;
    find_nxt    = find_r;
    age_in_nxt  = age_in_r;
    base_nxt    = base_r;
    mism_nxt    = mism_r;
    status_nxt  = status_r;
    fage_nxt    = fage_r;
    v_we        = 1'b0;
    v_wa        = clr_idx_r;
    v_wd        = 1'b0;
    a_we        = 1'b0;
    n_we        = 1'b0;
    n_re        = (st_r == TS_RUN) && find_r;
    n_ra        = base_r + NADDR_W'(idx_r);
    n_wa        = base_r + NADDR_W'(pidx_r);
    // bytes past the key length are zero padding
    key_byte    = (LEN_W'(pidx_r) < len_r) ? key_q_r : '0;
    byte_diff   = (key_byte != name_q_r);

    case (st_r)
      TS_CLEAR: begin
        v_we = 1'b1;
        if (clr_idx_r == SLOT_LAST) begin
          st_nxt = TS_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      TS_IDLE: begin
        if (req.start) begin
          slot_nxt   = req_slot;
          len_nxt    = req_len;
          find_nxt   = req.is_find;
          age_in_nxt = req.age;
          base_nxt   = NADDR_W'(req_slot * KEY_MAX);
          st_nxt     = TS_CHECK;
        end
      end
      TS_CHECK: begin
        idx_nxt     = '0;
        issuing_nxt = 1'b1;
        mism_nxt    = 1'b0;
        fage_nxt    = '0;
        if (find_r) begin
          if (valid_q_r) begin
            fage_nxt = age_q_r;
            st_nxt   = TS_RUN;
          end else begin
            status_nxt = STAT_MISS;
            st_nxt     = TS_DONE;
          end
        end else if (valid_q_r) begin
          status_nxt = STAT_MISS;
          st_nxt     = TS_DONE;
        end else begin
          st_nxt = TS_RUN;
        end
      end
      TS_RUN: begin
        // issue side: one key byte (and, on a find, stored byte) read per cycle
        if (issuing_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r;
          if (idx_r == KEY_LAST) begin
            issuing_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // data side: copy or compare the byte read last cycle
        if (pv_r) begin
          if (!find_r) begin
            n_we = 1'b1;
          end else if (byte_diff) begin
            mism_nxt = 1'b1;
          end
          if (pidx_r == KEY_LAST) begin
            st_nxt = TS_DONE;
            if (!find_r) begin
              v_we       = 1'b1;
              v_wa       = slot_r;
              v_wd       = 1'b1;
              a_we       = 1'b1;
              status_nxt = STAT_OK;
            end else if (mism_r || byte_diff) begin
              status_nxt = STAT_MISS;
              fage_nxt   = '0;
            end else begin
              status_nxt = STAT_OK;
            end
          end
        end
      end
      TS_DONE: begin
        if (resp_ack) begin
          st_nxt = TS_IDLE;
        end
      end
      default: begin
        st_nxt = TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= TS_CLEAR;
      clr_idx_r <= '0;
      issuing_r <= 1'b0;
      pv_r      <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_idx_r <= clr_idx_nxt;
      issuing_r <= issuing_nxt;
      pv_r      <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    slot_r   <= slot_nxt;
    len_r    <= len_nxt;
    find_r   <= find_nxt;
    age_in_r <= age_in_nxt;
    base_r   <= base_nxt;
    mism_r   <= mism_nxt;
    status_r <= status_nxt;
    fage_r   <= fage_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (v_we) begin
      valid_mem[v_wa] <= v_wd;
    end
    if (req.start) begin
      valid_q_r <= valid_mem[req_slot];
    end
  end

  // stored ages
  always_ff @(posedge clk) begin
    if (a_we) begin
      age_mem[slot_r] <= age_in_r;
    end
    if (req.start) begin
      age_q_r <= age_mem[req_slot];
    end
  end

  // stored names, KEY_MAX bytes per slot
  always_ff @(posedge clk) begin
    if (n_we) begin
      name_mem[n_wa] <= key_byte;
    end
    if (n_re) begin
      name_q_r <= name_mem[n_ra];
    end
  end

  // key buffer for the name being streamed in
  always_ff @(posedge clk) begin
    if (kwr_en) begin
      key_mem[kwr_addr] <= kwr_data;
    end
    key_q_r <= key_mem[idx_r];
  end

  always_comb begin
    resp.ready     = (st_r == TS_IDLE);
    resp.done      = (st_r == TS_DONE);
    resp.status    = status_r;
    resp.found_age = fage_r;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (st_r == TS_IDLE))
    else $error("table request while sequencer busy");

  a_no_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    resp.done |-> (resp.status == STAT_OK || resp.status == STAT_MISS))
    else $error("table returned an invalid status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (resp.done && resp.status != STAT_OK) |-> (resp.found_age == '0))
    else $error("nonzero age on a failed lookup");

  a_insert_age: assert property (@(posedge clk) disable iff (!rst_n)
    (resp.done && !find_r) |-> (resp.found_age == '0))
    else $error("nonzero age reported for an insert");

endmodule

`default_nettype wire

/* src/string_keyed_hash_table.sv */
// ---------------------------------------------------------------------------
// string_keyed_hash_table
// Direct-mapped hash table keyed by a streamed name; insert and find.
// ---------------------------------------------------------------------------
// Characters: one that fits goes through the 3-stage hash unit (add-multiply,
//   reciprocal multiply, multiply-subtract) before the next is accepted; a
//   dropped overflow character does not wait on the hash unit.
// Result: the table copies or compares the name byte by byte unless the slot
//   check alone decides; a too-long name skips the table; out_tready stalls delay it.
// Reset: synchronous, active low; a valid-bit clear pass over every slot follows.
`timescale 1ns / 1ps
`default_nettype none

module string_keyed_hash_table #(
  parameter int TABLE_ENTRIES = skt_pkg::DEF_TABLE_ENTRIES,
  parameter int NAME_BYTES    = skt_pkg::DEF_NAME_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [7:0] name_char, [39:8] age
  input  wire logic [0:0]  in_tuser,   // [0] req_type
  input  wire logic        in_tlast,   // last_char
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [1:0] status, [8:2] slot_index,
                                       // [40:9] found_age, [47:41] zero
);
  import skt_pkg::*;

  localparam int KEY_MAX = NAME_BYTES - 1;
  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int LEN_W   = $clog2(NAME_BYTES);
  localparam int KIDX_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int OUT_W   = 48;

  // top-level sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // ready for a character
  localparam logic [1:0] S_HASH  = 2'd1;  // waiting on the hash step
  localparam logic [1:0] S_ISSUE = 2'd2;  // name complete, start table work or report too long
  localparam logic [1:0] S_TABLE = 2'd3;  // table sequencer running

  logic [1:0]        st_r, st_nxt;
  logic [SLOT_W-1:0] h_r, h_nxt;         // running hash
  logic [LEN_W-1:0]  len_r, len_nxt;     // characters buffered so far
  logic              tl_r, tl_nxt;       // name overflowed the key buffer
  logic              last_r, last_nxt;   // current character closes the name
  logic              req_r, req_nxt;     // request kind of the last transaction
  logic [AGE_W-1:0]  age_r, age_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic              accept, room, out_free, out_load, clear_key;
  logic [CHAR_W-1:0] in_char;
  logic [AGE_W-1:0]  in_age;
  logic              hash_start, hash_done;
  logic [SLOT_W-1:0] hash_h;
  logic              kwr_en;
  logic [KIDX_W-1:0] kwr_addr;
  tbl_req_t          tbl_req;
  tbl_resp_t         tbl_resp;
  logic              tbl_ack;
  logic [STATUS_W-1:0]   ld_stat;
  logic [SLOT_OUT_W-1:0] ld_slot;
  logic [AGE_W-1:0]      ld_age;
  logic [15:0]           h_wide;

  assign in_char   = in_tdata[7:0];
  assign in_age    = in_tdata[39:8];
  assign in_tready = (st_r == S_IDLE) && tbl_resp.ready;
  assign accept    = in_tvalid && in_tready;
  assign room      = (len_r < LEN_W'(KEY_MAX));
  assign out_free  = !out_tvalid_r || out_tready;

  // a character that fits goes to the key buffer and the hash unit
  assign hash_start = accept && room;
  assign kwr_en     = hash_start;
  assign kwr_addr   = len_r[KIDX_W-1:0];

  // reported slot is the hash masked to the slot_index width
  assign h_wide = 16'(h_r);

  always_comb begin
    st_nxt    = st_r;
    h_nxt     = h_r;
    len_nxt   = len_r;
    tl_nxt    = tl_r;
    last_nxt  = last_r;
    req_nxt   = req_r;
    age_nxt   = age_r;
    out_load  = 1'b0;
    clear_key = 1'b0;
    ld_stat   = STAT_OK;
    ld_slot   = '0;
    ld_age    = '0;
    tbl_ack   = 1'b0;
    tbl_req   = '0;

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt  = in_tuser[0];
          age_nxt  = in_age;
          last_nxt = in_tlast;
          if (room) begin
            len_nxt = len_r + 1'b1;
            st_nxt  = S_HASH;
          end else begin
            // overflow character: dropped, hash untouched
            tl_nxt = 1'b1;
            st_nxt = in_tlast ? S_ISSUE : S_IDLE;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          h_nxt  = hash_h;
          st_nxt = last_r ? S_ISSUE : S_IDLE;
        end
      end
      S_ISSUE: begin
        if (tl_r) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_stat   = STAT_TOO_LONG;
            clear_key = 1'b1;
            st_nxt    = S_IDLE;
          end
        end else begin
          tbl_req.start   = 1'b1;
          tbl_req.is_find = req_r;
          tbl_req.age     = age_r;
          st_nxt          = S_TABLE;
        end
      end
      S_TABLE: begin
        if (tbl_resp.done && out_free) begin
          out_load  = 1'b1;
          ld_stat   = tbl_resp.status;
          ld_slot   = h_wide[SLOT_OUT_W-1:0];
          ld_age    = tbl_resp.found_age;
          tbl_ack   = 1'b1;
          clear_key = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // name finished: back to an empty key
    if (clear_key) begin
      h_nxt    = '0;
      len_nxt  = '0;
      tl_nxt   = 1'b0;
      last_nxt = 1'b0;
    end
  end

  // output register: a finished transaction waits here while the next
  // name streams in
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_W'({ld_age, ld_slot, ld_stat});
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      h_r          <= '0;
      len_r        <= '0;
      tl_r         <= 1'b0;
      last_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      h_r          <= h_nxt;
      len_r        <= len_nxt;
      tl_r         <= tl_nxt;
      last_r       <= last_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    age_r       <= age_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  skt_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .h_in    (h_r),
    .char_in (in_char),
    .done    (hash_done),
    .h_out   (hash_h)
  );

  skt_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NAME_BYTES    (NAME_BYTES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .kwr_en   (kwr_en),
    .kwr_addr (kwr_addr),
    .kwr_data (in_char),
    .req      (tbl_req),
    .req_slot (h_r),
    .req_len  (len_r),
    .resp_ack (tbl_ack),
    .resp     (tbl_resp)
  );

  a_too_long_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[1:0] == STAT_TOO_LONG) |-> (out_tdata_r[40:2] == '0))
    else $error("too-long transaction carries a slot or age");

  a_table_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TABLE) |-> !tl_r)
    else $error("table work started for an overlong name");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= KEY_MAX)
    else $error("key length beyond buffer size");

endmodule

`default_nettype wire

/* tb/tb_string_keyed_hash_table.sv */
// ---------------------------------------------------------------------------
// tb_string_keyed_hash_table
// Self-checking bench for the string keyed hash table: names stream in one
// character per transaction, a local copy of the table predicts each
// insert/find status, slot and age, and every result transaction is checked
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_string_keyed_hash_table;

  import skt_pkg::*;

  localparam int ENTRIES     = DEF_TABLE_ENTRIES;
  localparam int KEY_MAX     = DEF_NAME_BYTES - 1;  // longest name that fits
  localparam int TOTAL_ITEMS = 950;
  localparam int CALM_ITEMS  = 120;                 // closing stretch, no idling

  // request kinds carried in tuser on the last character
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [AGE_W-1:0]      age;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] name_char, [39:8] age
  logic [0:0]  in_tuser;   // [0] req_type
  logic        in_tlast;   // last_char
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [1:0] status, [8:2] slot_index, [40:9] found_age

  string_keyed_hash_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // -------------------------------------------------------------------------
  // Local copy of the table and of the name being assembled
  // -------------------------------------------------------------------------
  int unsigned hash_acc;
  logic [7:0]  key_buf [KEY_MAX];
  int          key_len;
  bit          overlong;
  bit          tbl_valid [ENTRIES];
  logic [7:0]  tbl_name  [ENTRIES][KEY_MAX];
  logic [31:0] tbl_age   [ENTRIES];
  int          tbl_len   [ENTRIES];   // stored name length, only for reusing stored names

  result_t     pending_results[$];    // predictions not yet matched by a result
  logic [7:0]  name_q[$];             // name about to be streamed
  int          items_sent;
  int          errors;
  bit          idle_in;               // random source gaps enabled
  bit          stall_out;             // random sink stalls enabled

  // Clock: 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Prediction: fold one accepted character into the running name. On the
  // last character, resolve the request against the hashed slot and queue
  // the expected result, then start a fresh name.
  // -------------------------------------------------------------------------
  task automatic apply_char(input logic req, input logic [7:0] ch, input logic last,
                            input logic [31:0] age);
    result_t     r;
    int unsigned slot;
    bit          same;
    if (key_len < KEY_MAX) begin
      key_buf[key_len] = ch;
      key_len++;
      hash_acc = ((hash_acc + ch) * ch) % ENTRIES;
    end else begin
      // character beyond the limit is dropped, hash untouched
      overlong = 1'b1;
    end
    if (last) begin
      r.status = STAT_OK;
      r.slot   = '0;
      r.age    = '0;
      if (overlong) begin
        r.status = STAT_TOO_LONG;
      end else begin
        slot   = hash_acc % ENTRIES;
        r.slot = slot[SLOT_OUT_W-1:0];
        if (req == REQ_INSERT) begin
          if (tbl_valid[slot]) begin
            r.status = STAT_MISS;     // slot taken, no probing
          end else begin
            tbl_name[slot]  = key_buf;
            tbl_age[slot]   = age;
            tbl_len[slot]   = key_len;
            tbl_valid[slot] = 1'b1;
          end
        end else begin
          // names compare as zero-padded buffers
          same = tbl_valid[slot];
          for (int i = 0; i < KEY_MAX; i++)
            if (tbl_name[slot][i] != key_buf[i]) same = 1'b0;
          if (same) r.age = tbl_age[slot];
          else r.status = STAT_MISS;
        end
      end
      pending_results.push_back(r);
      hash_acc = 0;
      key_len  = 0;
      overlong = 1'b0;
      foreach (key_buf[i]) key_buf[i] = 8'h00;
    end
  endtask

  // -------------------------------------------------------------------------
  // Source side: one input transaction, with an optional idle burst first.
  // The prediction is updated at the edge where the transaction completes.
  // -------------------------------------------------------------------------
  task automatic send_char(input logic req, input logic [7:0] ch, input logic last,
                           input logic [31:0] age);
    if (idle_in && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {age, ch};
    in_tuser  <= req;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    apply_char(req, ch, last, age);
  endtask

  // Stream name_q; kind and age on earlier characters are junk the block
  // must ignore.
  task automatic send_name(input logic req, input logic [31:0] age);
    int n;
    n = name_q.size();
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_char(req, name_q[i], 1'b1, age);
      else send_char(1'($urandom), name_q[i], 1'b0, $urandom);
    end
  endtask

  task automatic random_name(input int len);
    name_q.delete();
    repeat (len) name_q.push_back(8'($urandom));
  endtask

  // mostly short names so slots fill and collide; now and then a long one
  function automatic int rand_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, KEY_MAX);
    return $urandom_range(1, 6);
  endfunction

  // load the name of some occupied slot, if one turns up in a few tries
  function automatic bit pick_stored_name();
    int s;
    for (int k = 0; k < 8; k++) begin
      s = $urandom_range(0, ENTRIES - 1);
      if (tbl_valid[s]) begin
        name_q.delete();
        for (int i = 0; i < tbl_len[s]; i++) name_q.push_back(tbl_name[s][i]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // -------------------------------------------------------------------------
  // Sink side: random stall bursts on out_tready, and a check of every
  // result transaction against the oldest prediction.
  // -------------------------------------------------------------------------
  initial begin : result_monitor
    int      stall_left;
    result_t got;
    result_t want;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.slot   = out_tdata[8:2];
        got.age    = out_tdata[40:9];
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d slot %0d age %0h",
                   $time, got.status, got.slot, got.age);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                     $time, want.slot, got.slot);
            errors++;
          end
          if (got.age !== want.age) begin
            $display("%0t: found_age mismatch: expected %0h, actual %0h",
                     $time, want.age, got.age);
            errors++;
          end
        end
      end
      // random stall bursts while stall_out is set
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stall_out && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // single-character names with extreme ages: insert into an empty slot,
  // hit, occupied slot on a second insert, miss on an empty slot
  task automatic test_basic_insert_find();
    name_q = '{8'hFF};
    send_name(REQ_INSERT, 32'h7FFF_FFFF);
    send_name(REQ_FIND, 32'h0000_0000);
    send_name(REQ_INSERT, 32'h0000_0000);
    name_q = '{8'h01};
    send_name(REQ_INSERT, 32'hFFFF_FFFF);
    send_name(REQ_FIND, 32'h1234_5678);
    name_q = '{8'h02};
    send_name(REQ_FIND, 32'hFFFF_FFFF);
  endtask

  // a zero character is an ordinary value; trailing zeros still match, and
  // a different name landing on the same slot misses
  task automatic test_zero_char_and_collision();
    name_q = '{8'h00};
    send_name(REQ_INSERT, 32'h8000_0000);
    name_q = '{8'h00, 8'h00, 8'h00};
    send_name(REQ_FIND, 32'h0);
    name_q = '{8'hFF, 8'h00};
    send_name(REQ_FIND, 32'h0);
    send_name(REQ_INSERT, 32'h5555_AAAA);
  endtask

  // kind and age are only taken from the last character
  task automatic test_early_fields_ignored();
    name_q = '{8'h41, 8'h42, 8'h43};
    send_name(REQ_INSERT, 32'hA5A5_5A5A);
    send_name(REQ_FIND, 32'h0);
  endtask

  // longest name that fits, then names one and two past the limit
  task automatic test_name_length_limit();
    random_name(KEY_MAX);
    send_name(REQ_INSERT, $urandom);
    send_name(REQ_FIND, $urandom);
    random_name(KEY_MAX + 1);
    send_name(REQ_INSERT, $urandom);
    random_name(KEY_MAX + 2);
    send_name(REQ_FIND, $urandom);
  endtask

  // mixed inserts and finds until the item count reaches stop_at
  task automatic run_mixed_traffic(input int stop_at);
    int pick;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        random_name($urandom_range(KEY_MAX + 1, KEY_MAX + 6));
        send_name(1'($urandom), $urandom);
      end else if (pick < 45) begin
        // some inserts reuse a stored name to hit the occupied case
        if (!(pick < 10 && pick_stored_name())) random_name(rand_len());
        send_name(REQ_INSERT, $urandom);
      end else begin
        // most finds look up a stored name, sometimes with a trailing zero
        if (pick < 80 && pick_stored_name()) begin
          if ($urandom_range(0, 7) == 0) name_q.push_back(8'h00);
        end else begin
          random_name(rand_len());
        end
        send_name(REQ_FIND, $urandom);
      end
    end
  endtask

  task automatic test_random_traffic();
    idle_in   = 1'b1;
    stall_out = 1'b1;
    run_mixed_traffic(TOTAL_ITEMS - CALM_ITEMS);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_unthrottled_traffic();
    idle_in   = 1'b0;
    stall_out = 1'b0;
    run_mixed_traffic(TOTAL_ITEMS);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    hash_acc   = 0;
    key_len    = 0;
    overlong   = 1'b0;
    items_sent = 0;
    errors     = 0;
    idle_in    = 1'b1;
    stall_out  = 1'b1;
    foreach (key_buf[i]) key_buf[i] = 8'h00;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_age[i]   = '0;
      tbl_len[i]   = 0;
      for (int j = 0; j < KEY_MAX; j++) tbl_name[i][j] = 8'h00;
    end

    // release reset; the block then clears its valid bits with
    // in_tready low, which the first handshake simply waits out
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_insert_find();
    test_zero_char_and_collision();
    test_early_fields_ignored();
    test_name_length_limit();
    test_random_traffic();
    test_unthrottled_traffic();
    in_tvalid <= 1'b0;

    // drain, then give a late or extra result time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEF_NAME_BYTES + 16) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
